### rtl/assert_macros.svh
// Assertion macros shared by the envelope RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CHK_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_CHK_NR(lbl, prop, msg)
`endif
`endif

### rtl/gae_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the gated ADSR envelope.
// No dependencies.
package gae_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int TIME_W  = 48;
    localparam int LVL_W   = 17;
    localparam int DUR_W   = 16;
    localparam int NUM_W   = 33;
    localparam int QUOT_W  = 17;
    localparam int PADDR_W = 4;

    localparam logic [LVL_W-1:0] FULL_SCALE = 17'd65536;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    typedef struct packed {
        logic [3:0]        channel;
        logic              gate;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [3:0]       out_channel;
        logic [LVL_W-1:0] level;
        logic             level_changed;
    } result_t;

    typedef struct packed {
        logic              gate_held;
        logic [TIME_W-1:0] switch_time;
        logic [LVL_W-1:0]  switch_level;
        logic [LVL_W-1:0]  current_level;
    } ch_state_t;

    typedef enum logic [2:0] {
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE,
        PH_ZERO
    } phase_t;

endpackage

### rtl/gae_mem.sv
`timescale 1ns / 1ps
// Per-channel envelope state memory with a registered read.
// Uses gae_pkg; entries never written read as zero.
module gae_mem
    import gae_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int AW       = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output ch_state_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  ch_state_t     wr_data
);

    ch_state_t mem_reg [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    ch_state_t data_reg;
    logic rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? data_reg : '0;

endmodule

### rtl/gae_div.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Uses gae_pkg; caller guarantees num < den * 2**QUOT_W and den != 0.
module gae_div
    import gae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DUR_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [DUR_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DUR_W:0]    part;
    logic [DUR_W+1:0]  diff;

    always_comb
    begin
        part      = {rem_reg, q_reg[QUOT_W-1]};
        diff      = {1'b0, part} - {2'b00, den_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[NUM_W-1:QUOT_W];
            q_next   = num[QUOT_W-1:0];
            cnt_next = CNT_W'(QUOT_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DUR_W+1])
            begin
                rem_next = diff[DUR_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = part[DUR_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/gated_adsr_envelope.sv
// Gated ADSR envelope, per-channel state in a one-read-port memory.
// An item that needs a division passes through state read, phase select, multiply,
// 17 divider steps, done flag and write-back; the divider is skipped otherwise, and an
// out-of-range channel goes straight to the final state. No new item is accepted until the last result is issued.
// Reset clears control, config to defaults and marks all channel state as zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gated_adsr_envelope
    import gae_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_PHASE = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t st_reg, st_next;

    // configuration
    logic [DUR_W-1:0] attack_reg, decay_reg, release_reg;
    logic [LVL_W-1:0] sustain_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= FULL_SCALE;
            release_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ATTACK:  attack_reg  <= pwdata[DUR_W-1:0];
                REG_DECAY:   decay_reg   <= pwdata[DUR_W-1:0];
                REG_SUSTAIN: sustain_reg <= pwdata[LVL_W-1:0];
                REG_RELEASE: release_reg <= pwdata[DUR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ATTACK:  prdata = 32'(attack_reg);
            REG_DECAY:   prdata = 32'(decay_reg);
            REG_SUSTAIN: prdata = 32'(sustain_reg);
            REG_RELEASE: prdata = 32'(release_reg);
            default:     prdata = '0;
        endcase
    end

    // item registers
    item_t             item_reg;
    logic              oor_reg;
    logic [TIME_W-1:0] el_reg, swt_reg;
    logic [LVL_W-1:0]  swl_reg, prev_reg;
    phase_t            ph_reg, ph_next;
    logic [LVL_W-1:0]  mul_a_reg, mul_a_next;
    logic [DUR_W-1:0]  mul_b_reg, mul_b_next;
    logic [DUR_W-1:0]  den_reg, den_next;
    logic              result_valid_reg;
    result_t           result_reg;

    logic              accept;
    logic              out_free;
    logic              oor_in;
    logic [AW+3:0]     ch_ext;
    logic [AW-1:0]     ch_addr;
    ch_state_t         rd_data, wr_data;
    logic              wr_en;
    logic              sw_chg;
    logic [TIME_W-1:0] swt_sel, el_calc;
    logic [LVL_W-1:0]  swl_sel;
    logic [LVL_W-1:0]  sus;
    logic [LVL_W-1:0]  ad_sum;
    logic [LVL_W-1:0]  dd;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  product;
    logic [QUOT_W-1:0] quot;
    logic [LVL_W:0]    lvl_raw;
    logic [LVL_W-1:0]  lvl, dec_v;

    assign item_stall = (st_reg != S_IDLE);
    assign accept     = item_valid & ~item_stall;
    assign out_free   = ~result_valid_reg | ~result_stall;
    assign oor_in     = ({5'd0, item.channel} >= 9'(CHANNELS));
    assign ch_ext     = {{AW{1'b0}}, item_reg.channel};
    assign ch_addr    = ch_ext[AW-1:0];
    assign sus        = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;

    // the read address comes from the input directly at acceptance
    logic [AW+3:0] in_ext;
    logic [AW-1:0] in_addr;
    assign in_ext  = {{AW{1'b0}}, item.channel};
    assign in_addr = in_ext[AW-1:0];

    gae_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ch_addr),
        .wr_data (wr_data)
    );

    // switch bookkeeping on the fresh read
    always_comb
    begin
        sw_chg  = (item_reg.gate != rd_data.gate_held);
        swt_sel = sw_chg ? item_reg.time_ms : rd_data.switch_time;
        swl_sel = sw_chg ? rd_data.current_level : rd_data.switch_level;
        el_calc = (item_reg.time_ms >= swt_sel) ? (item_reg.time_ms - swt_sel) : '0;
    end

    // phase select and divider operands
    always_comb
    begin
        ad_sum     = {1'b0, attack_reg} + {1'b0, decay_reg};
        dd         = el_reg[LVL_W-1:0] - {1'b0, attack_reg};
        ph_next    = PH_ZERO;
        mul_a_next = '0;
        mul_b_next = '0;
        den_next   = '0;
        if (item_reg.gate)
        begin
            if (el_reg < TIME_W'(attack_reg))
            begin
                ph_next    = PH_ATTACK;
                mul_a_next = FULL_SCALE - swl_reg;
                mul_b_next = el_reg[DUR_W-1:0];
                den_next   = attack_reg;
            end
            else if (el_reg < TIME_W'(ad_sum))
            begin
                ph_next    = PH_DECAY;
                mul_a_next = FULL_SCALE;
                mul_b_next = dd[DUR_W-1:0];
                den_next   = decay_reg;
            end
            else
            begin
                ph_next = PH_SUSTAIN;
            end
        end
        else if (el_reg < TIME_W'(release_reg))
        begin
            ph_next    = PH_RELEASE;
            mul_a_next = swl_reg;
            mul_b_next = release_reg - el_reg[DUR_W-1:0];
            den_next   = release_reg;
        end
    end

    assign product   = NUM_W'(mul_a_reg) * NUM_W'(mul_b_reg);
    assign div_start = (st_reg == S_MUL) &&
                       (ph_reg == PH_ATTACK || ph_reg == PH_DECAY || ph_reg == PH_RELEASE);

    gae_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // final level
    always_comb
    begin
        dec_v = FULL_SCALE - quot;
        unique case (ph_reg)
            PH_ATTACK:  lvl_raw = {1'b0, swl_reg} + {1'b0, quot};
            PH_DECAY:   lvl_raw = {1'b0, (dec_v > sus) ? dec_v : sus};
            PH_SUSTAIN: lvl_raw = {1'b0, sus};
            PH_RELEASE: lvl_raw = {1'b0, quot};
            default:    lvl_raw = '0;
        endcase
        if (oor_reg)
        begin
            lvl = '0;
        end
        else if (lvl_raw > {1'b0, FULL_SCALE})
        begin
            lvl = FULL_SCALE;
        end
        else
        begin
            lvl = lvl_raw[LVL_W-1:0];
        end
    end

    assign wr_en = (st_reg == S_FIN) && out_free && !oor_reg;
    assign wr_data = '{gate_held: item_reg.gate, switch_time: swt_reg,
                       switch_level: swl_reg, current_level: lvl};

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (accept) st_next = oor_in ? S_FIN : S_READ;
            S_READ:  st_next = S_PHASE;
            S_PHASE: st_next = S_MUL;
            S_MUL:   st_next = div_start ? S_DIV : S_FIN;
            S_DIV:   if (div_done) st_next = S_FIN;
            S_FIN:   if (out_free) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= S_IDLE;
            result_valid_reg <= 1'b0;
            oor_reg          <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept)
            begin
                oor_reg <= oor_in;
            end
            if (st_reg == S_FIN && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (st_reg == S_READ)
        begin
            el_reg   <= el_calc;
            swt_reg  <= swt_sel;
            swl_reg  <= swl_sel;
            prev_reg <= rd_data.current_level;
        end
        if (st_reg == S_PHASE)
        begin
            ph_reg    <= ph_next;
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            den_reg   <= den_next;
        end
        if (st_reg == S_FIN && out_free)
        begin
            result_reg.out_channel   <= item_reg.channel;
            result_reg.level         <= lvl;
            result_reg.level_changed <= !oor_reg && (lvl != prev_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_CHK(a_div_den_nonzero, div_start |-> den_reg != '0, "divider started with zero divisor")
    `ASSERT_CHK(a_div_done_in_div, div_done |-> st_reg == S_DIV, "divider finished outside wait state")
    `ASSERT_CHK(a_level_range, result_valid_reg |-> result_reg.level <= FULL_SCALE, "level above full scale")

endmodule
